@@ sv/retired_page_ready_stack_top_assert.svh @@
// Assertion macros used by the checker of this block.
`ifndef RETIRED_PAGE_READY_STACK_TOP_ASSERT_SVH
`define RETIRED_PAGE_READY_STACK_TOP_ASSERT_SVH

// Same-cycle implication.
`define RPRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rprs assertion failed");

// Next-cycle implication.
`define RPRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rprs assertion failed");

`endif

@@ sv/rprs_pkg.sv @@
`timescale 1ns / 1ps

package rprs_pkg;

  localparam int NUM_PAGES_DEF  = 256;
  localparam int NUM_STACKS_DEF = 4;
  localparam int COUNT_BITS_DEF = 16;

  localparam int PAGE_IN_W  = 8;
  localparam int STACK_IN_W = 2;
  localparam int COUNT_IN_W = 16;
  localparam int TOTAL_W    = 32;

  typedef enum logic [1:0] {
    MODE_MARK   = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_POP    = 2'd2,
    MODE_CANCEL = 2'd3
  } mode_t;

  // Update request from the sequencer to the stack register file.
  typedef struct packed {
    logic head_we;
    logic push;
  } stk_upd_t;

endpackage

@@ sv/rprs_page_mem.sv @@
`timescale 1ns / 1ps

module rprs_page_mem #(
  parameter int DEPTH  = rprs_pkg::NUM_PAGES_DEF,
  parameter int ADDR_W = 8,
  parameter int WORD_W = 30
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/rprs_stack_file.sv @@
`timescale 1ns / 1ps

module rprs_stack_file #(
  parameter int NUM_STACKS = rprs_pkg::NUM_STACKS_DEF,
  parameter int SW         = 2,
  parameter int LW         = 9
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [SW-1:0]              rd_idx,
  output logic [LW-1:0]              rd_head,
  output logic [rprs_pkg::TOTAL_W-1:0] rd_count,
  input  rprs_pkg::stk_upd_t         upd,
  input  logic [SW-1:0]              wr_idx,
  input  logic [LW-1:0]              wr_head
);

  localparam logic [LW-1:0] HEAD_NULL = {1'b1, {(LW-1){1'b0}}};

  logic [LW-1:0]                 head_r [NUM_STACKS];
  logic [rprs_pkg::TOTAL_W-1:0]  pc_r   [NUM_STACKS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        head_r[i] <= HEAD_NULL;
        pc_r[i]   <= '0;
      end
    end else begin
      if (upd.head_we) begin
        head_r[wr_idx] <= wr_head;
      end
      if (upd.push) begin
        pc_r[wr_idx] <= pc_r[wr_idx] + rprs_pkg::TOTAL_W'(1);
      end
    end
  end

  assign rd_head  = head_r[rd_idx];
  assign rd_count = pc_r[rd_idx];

endmodule

@@ sv/retired_page_ready_stack_top.sv @@
`timescale 1ns / 1ps
// Channel   Handshake            Ports
// input     start & !busy        in_mode, in_page_index, in_stack_index,
//                                in_outstanding_count
// result    out_valid (1 cycle)  out_ok, out_popped_page, out_push_total
//
// Each transaction is the page memory read, then modify and write back; busy
// is high for the modify cycle, so no new transaction is taken until the last
// one is written back. The result strobe comes the cycle after busy falls.
// After reset a clearing pass writes every page entry with busy high. The
// receiver cannot stall; results are never held back.

module retired_page_ready_stack_top #(
  parameter int NUM_PAGES  = rprs_pkg::NUM_PAGES_DEF,
  parameter int NUM_STACKS = rprs_pkg::NUM_STACKS_DEF,
  parameter int COUNT_BITS = rprs_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_mode,
  input  logic [rprs_pkg::PAGE_IN_W-1:0]     in_page_index,
  input  logic [rprs_pkg::STACK_IN_W-1:0]    in_stack_index,
  input  logic [rprs_pkg::COUNT_IN_W-1:0]    in_outstanding_count,
  output logic                               out_valid,
  output logic                               out_ok,
  output logic [rprs_pkg::PAGE_IN_W-1:0]     out_popped_page,
  output logic [rprs_pkg::TOTAL_W-1:0]       out_push_total
);

  localparam int PW     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int SW     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int LW     = PW + 1;
  localparam int WORD_W = 1 + COUNT_BITS + 1 + SW + LW;
  localparam int PG_TBL = 2 ** rprs_pkg::PAGE_IN_W;
  localparam int SK_TBL = 2 ** rprs_pkg::STACK_IN_W;
  localparam logic [LW-1:0] LINK_NULL = {1'b1, {PW{1'b0}}};
  localparam logic [PW-1:0] LAST_PAGE = PW'(NUM_PAGES - 1);

  // Index wrap tables, worked out at elaboration.
  logic [PW-1:0] pg_wrap_tbl [PG_TBL];
  logic [SW-1:0] sk_wrap_tbl [SK_TBL];

  for (genvar i = 0; i < PG_TBL; i++) begin : g_pg_wrap
    assign pg_wrap_tbl[i] = PW'(i % NUM_PAGES);
  end
  for (genvar i = 0; i < SK_TBL; i++) begin : g_sk_wrap
    assign sk_wrap_tbl[i] = SW'(i % NUM_STACKS);
  end

  logic                  clr_r;
  logic [PW-1:0]         clr_idx_r;
  logic                  exec_r;
  rprs_pkg::mode_t       mode_r;
  logic [PW-1:0]         pg_r;
  logic [SW-1:0]         stk_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [LW-1:0]         hd_r;

  logic                              out_valid_r;
  logic                              out_ok_r;
  logic [rprs_pkg::PAGE_IN_W-1:0]    out_popped_r;
  logic [rprs_pkg::TOTAL_W-1:0]      out_total_r;

  logic                  accept;
  rprs_pkg::mode_t       in_mode_c;
  logic [PW-1:0]         in_pg_w;
  logic [SW-1:0]         in_stk_w;

  logic [PW-1:0]         mem_rd_addr;
  logic [WORD_W-1:0]     mem_rd_data;
  logic                  mem_we;
  logic [PW-1:0]         mem_wr_addr;
  logic [WORD_W-1:0]     mem_wr_data;

  logic                  ent_ready;
  logic [COUNT_BITS-1:0] ent_cnt;
  logic                  ent_onstk;
  logic [SW-1:0]         ent_owner;
  logic [LW-1:0]         ent_link;

  logic [SW-1:0]                 stk_rd_idx;
  logic [LW-1:0]                 stk_head;
  logic [rprs_pkg::TOTAL_W-1:0]  stk_count;
  rprs_pkg::stk_upd_t            stk_upd;
  logic [SW-1:0]                 tgt;
  logic [LW-1:0]                 stk_wr_head;

  logic                              exec_we;
  logic [PW-1:0]                     exec_addr;
  logic [WORD_W-1:0]                 exec_data;
  logic                              res_ok;
  logic [rprs_pkg::PAGE_IN_W-1:0]    res_popped;
  logic [rprs_pkg::TOTAL_W-1:0]      res_total;
  logic [PW+rprs_pkg::PAGE_IN_W-1:0] hd_ext;

  assign busy      = clr_r | exec_r;
  assign accept    = start & ~busy;
  assign in_mode_c = rprs_pkg::mode_t'(in_mode);
  assign in_pg_w   = pg_wrap_tbl[in_page_index];
  assign in_stk_w  = sk_wrap_tbl[in_stack_index];

  assign {ent_ready, ent_cnt, ent_onstk, ent_owner, ent_link} = mem_rd_data;

  // Mark and pop concern the named stack; free and cancel the page's owner.
  assign tgt = (mode_r == rprs_pkg::MODE_MARK || mode_r == rprs_pkg::MODE_POP) ?
               stk_r : ent_owner;
  assign stk_rd_idx = exec_r ? tgt : in_stk_w;

  // Pop reads the entry under the head; everything else reads its page.
  assign mem_rd_addr = (in_mode_c == rprs_pkg::MODE_POP) ? stk_head[PW-1:0] : in_pg_w;

  assign hd_ext = {{rprs_pkg::PAGE_IN_W{1'b0}}, hd_r[PW-1:0]};

  always_comb begin
    exec_we     = 1'b1;
    exec_addr   = pg_r;
    exec_data   = mem_rd_data;
    res_ok      = 1'b0;
    res_popped  = '0;
    res_total   = stk_count;
    stk_upd     = '0;
    stk_wr_head = stk_head;
    unique case (mode_r)
      rprs_pkg::MODE_MARK: begin
        exec_data = {1'b1, cnt_r, ent_onstk, stk_r, ent_link};
        res_ok    = 1'b1;
      end
      rprs_pkg::MODE_FREE: begin
        if (ent_ready) begin
          if (ent_cnt == COUNT_BITS'(1)) begin
            // Last awaited free: disarm and push onto the owner's stack.
            exec_data        = {1'b0, {COUNT_BITS{1'b0}}, 1'b1, ent_owner, stk_head};
            stk_upd.head_we  = 1'b1;
            stk_upd.push     = 1'b1;
            stk_wr_head      = {1'b0, pg_r};
            res_ok           = 1'b1;
            res_total        = stk_count + rprs_pkg::TOTAL_W'(1);
          end else begin
            exec_data = {1'b1, ent_cnt - COUNT_BITS'(1), ent_onstk, ent_owner, ent_link};
          end
        end
      end
      rprs_pkg::MODE_POP: begin
        exec_addr = hd_r[PW-1:0];
        if (hd_r[LW-1]) begin
          exec_we = 1'b0;
        end else begin
          exec_data       = {ent_ready, ent_cnt, 1'b0, ent_owner, ent_link};
          stk_upd.head_we = 1'b1;
          stk_wr_head     = ent_link;
          res_ok          = 1'b1;
          res_popped      = hd_ext[rprs_pkg::PAGE_IN_W-1:0];
        end
      end
      rprs_pkg::MODE_CANCEL: begin
        exec_data = {1'b0, ent_cnt, ent_onstk, ent_owner, ent_link};
        res_ok    = ent_ready;
      end
      default: begin
        exec_we = 1'b0;
      end
    endcase
    if (!exec_r) begin
      exec_we = 1'b0;
      stk_upd = '0;
    end
  end

  assign mem_we      = clr_r | exec_we;
  assign mem_wr_addr = clr_r ? clr_idx_r : exec_addr;
  assign mem_wr_data = clr_r ? {{(WORD_W-LW){1'b0}}, LINK_NULL} : exec_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_idx_r   <= '0;
      exec_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + PW'(1);
        if (clr_idx_r == LAST_PAGE) begin
          clr_r <= 1'b0;
        end
      end
      exec_r      <= accept;
      out_valid_r <= exec_r;
    end
  end

  // Transaction fields and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode_c;
      pg_r   <= in_pg_w;
      stk_r  <= in_stk_w;
      cnt_r  <= COUNT_BITS'(in_outstanding_count);
      hd_r   <= stk_head;
    end
    if (exec_r) begin
      out_ok_r     <= res_ok;
      out_popped_r <= res_popped;
      out_total_r  <= res_total;
    end
  end

  rprs_page_mem #(
    .DEPTH  (NUM_PAGES),
    .ADDR_W (PW),
    .WORD_W (WORD_W)
  ) u_page_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  rprs_stack_file #(
    .NUM_STACKS (NUM_STACKS),
    .SW         (SW),
    .LW         (LW)
  ) u_stack_file (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (stk_rd_idx),
    .rd_head  (stk_head),
    .rd_count (stk_count),
    .upd      (stk_upd),
    .wr_idx   (tgt),
    .wr_head  (stk_wr_head)
  );

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_popped_page = out_popped_r;
  assign out_push_total  = out_total_r;

endmodule

@@ sv/rprs_checker.sv @@
`timescale 1ns / 1ps
`include "retired_page_ready_stack_top_assert.svh"

module rprs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic                            out_ok,
  input logic [rprs_pkg::PAGE_IN_W-1:0]  out_popped_page
);

  // Accepted transaction holds the block for its modify cycle.
  `RPRS_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // Every accepted transaction yields a result strobe.
  `RPRS_ASSERT_IMP(a_accept_result, start && !busy, ##2 out_valid)
  `RPRS_ASSERT_NXT(a_single_strobe, out_valid, !out_valid)
  `RPRS_ASSERT_IMP(a_result_idle, out_valid, !busy)
  // A nonzero popped page only comes from a successful pop.
  `RPRS_ASSERT_IMP(a_pop_ok, out_valid && out_popped_page != '0, out_ok)

endmodule

bind retired_page_ready_stack_top rprs_checker u_rprs_checker (.*);

@@ tb/sv/page_stack_checker.sv @@
`timescale 1ns / 1ps

module page_stack_checker
  import rprs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            in_mode,
  input  logic [PAGE_IN_W-1:0]  in_page_index,
  input  logic [STACK_IN_W-1:0] in_stack_index,
  input  logic [COUNT_IN_W-1:0] in_outstanding_count,
  input  logic                  out_valid,
  input  logic                  out_ok,
  input  logic [PAGE_IN_W-1:0]  out_popped_page,
  input  logic [TOTAL_W-1:0]    out_push_total,
  output int                    mismatches,
  output int                    pending
);

  typedef struct packed {
    logic                 ok;
    logic [PAGE_IN_W-1:0] page;
    logic [TOTAL_W-1:0]   total;
  } stack_result_t;

  localparam logic [PAGE_IN_W:0] LINK_NULL = (PAGE_IN_W + 1)'(NUM_PAGES_DEF);

  // Shadow copy of the page and stack state.
  logic                  armed     [NUM_PAGES_DEF];
  logic [COUNT_IN_W-1:0] frees_left[NUM_PAGES_DEF];
  logic                  on_stack  [NUM_PAGES_DEF];
  logic [STACK_IN_W-1:0] owner     [NUM_PAGES_DEF];
  logic [PAGE_IN_W:0]    link      [NUM_PAGES_DEF];
  logic [PAGE_IN_W:0]    head      [NUM_STACKS_DEF];
  logic [TOTAL_W-1:0]    pushes    [NUM_STACKS_DEF];

  stack_result_t expected_results[$];
  stack_result_t oldest;

  function automatic stack_result_t apply_page_op(mode_t m, logic [PAGE_IN_W-1:0] pg,
                                                  logic [STACK_IN_W-1:0] stk,
                                                  logic [COUNT_IN_W-1:0] cnt);
    stack_result_t         r;
    logic [STACK_IN_W-1:0] own;
    logic [PAGE_IN_W:0]    h;
    logic [COUNT_IN_W-1:0] prev;
    r = '0;
    own = owner[pg];
    case (m)
      MODE_MARK: begin
        owner[pg] = stk;
        frees_left[pg] = cnt;
        armed[pg] = 1'b1;
        r.ok = 1'b1;
        r.total = pushes[stk];
      end
      MODE_FREE: begin
        if (armed[pg]) begin
          prev = frees_left[pg];
          frees_left[pg] = prev - 1'b1;
          // last awaited free: disarm and push onto the owning stack
          if (prev == COUNT_IN_W'(1)) begin
            armed[pg] = 1'b0;
            on_stack[pg] = 1'b1;
            link[pg] = head[own];
            head[own] = {1'b0, pg};
            pushes[own] = pushes[own] + 1'b1;
            r.ok = 1'b1;
          end
        end
        r.total = pushes[own];
      end
      MODE_POP: begin
        h = head[stk];
        if (!h[PAGE_IN_W]) begin
          head[stk] = link[h[PAGE_IN_W-1:0]];
          on_stack[h[PAGE_IN_W-1:0]] = 1'b0;
          r.page = h[PAGE_IN_W-1:0];
          r.ok = 1'b1;
        end
        r.total = pushes[stk];
      end
      default: begin
        if (armed[pg]) begin
          armed[pg] = 1'b0;
          r.ok = 1'b1;
        end
        r.total = pushes[own];
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PAGES_DEF; i++) begin
        armed[i] = 1'b0;
        frees_left[i] = '0;
        on_stack[i] = 1'b0;
        owner[i] = '0;
        link[i] = '0;
      end
      for (int s = 0; s < NUM_STACKS_DEF; s++) begin
        head[s] = LINK_NULL;
        pushes[s] = '0;
      end
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          oldest = expected_results.pop_front();
          if (out_ok !== oldest.ok)
            report_mismatch($sformatf("ok got %b want %b", out_ok, oldest.ok));
          if (out_popped_page !== oldest.page)
            report_mismatch($sformatf("popped_page got %0d want %0d",
                                      out_popped_page, oldest.page));
          if (out_push_total !== oldest.total)
            report_mismatch($sformatf("push_total got %0d want %0d",
                                      out_push_total, oldest.total));
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_page_op(mode_t'(in_mode), in_page_index,
                                                 in_stack_index, in_outstanding_count));
      end
    end
    pending <= expected_results.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rprs_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_mode;
  logic [PAGE_IN_W-1:0]  in_page_index;
  logic [STACK_IN_W-1:0] in_stack_index;
  logic [COUNT_IN_W-1:0] in_outstanding_count;
  logic                  out_valid;
  logic                  out_ok;
  logic [PAGE_IN_W-1:0]  out_popped_page;
  logic [TOTAL_W-1:0]    out_push_total;

  int mismatches;
  int pending;
  int idle_pct;
  int sent;
  int idle_by_phase[3] = '{17, 50, 0};

  retired_page_ready_stack_top uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_mode              (in_mode),
    .in_page_index        (in_page_index),
    .in_stack_index       (in_stack_index),
    .in_outstanding_count (in_outstanding_count),
    .out_valid            (out_valid),
    .out_ok               (out_ok),
    .out_popped_page      (out_popped_page),
    .out_push_total       (out_push_total)
  );

  page_stack_checker chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_mode              (in_mode),
    .in_page_index        (in_page_index),
    .in_stack_index       (in_stack_index),
    .in_outstanding_count (in_outstanding_count),
    .out_valid            (out_valid),
    .out_ok               (out_ok),
    .out_popped_page      (out_popped_page),
    .out_push_total       (out_push_total),
    .mismatches           (mismatches),
    .pending              (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Hold the transaction until taken, then idle at random.
  task automatic send_op(mode_t m, logic [PAGE_IN_W-1:0] pg, logic [STACK_IN_W-1:0] stk,
                         logic [COUNT_IN_W-1:0] cnt);
    int gap;
    start <= 1'b1;
    in_mode <= m;
    in_page_index <= pg;
    in_stack_index <= stk;
    in_outstanding_count <= cnt;
    do @(posedge clk); while (busy);
    sent++;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly a small pool so that marks, frees and cancels meet the same pages.
  function automatic logic [PAGE_IN_W-1:0] pick_page();
    if ($urandom_range(0, 99) < 70) return PAGE_IN_W'($urandom_range(0, 15));
    return PAGE_IN_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [COUNT_IN_W-1:0] pick_count();
    if ($urandom_range(0, 99) < 80) return COUNT_IN_W'($urandom_range(0, 3));
    return COUNT_IN_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_noise();
    send_op(mode_t'($urandom_range(0, 3)), pick_page(),
            STACK_IN_W'($urandom_range(0, 3)), pick_count());
  endtask

  // Mark a page, deliver its frees, then usually pop its stack; else send one random op.
  task automatic send_round();
    logic [PAGE_IN_W-1:0]  pg;
    logic [STACK_IN_W-1:0] stk;
    int                    n;
    if ($urandom_range(0, 99) < 60) begin
      pg = pick_page();
      stk = STACK_IN_W'($urandom_range(0, 3));
      n = $urandom_range(1, 3);
      send_op(MODE_MARK, pg, stk, COUNT_IN_W'(n));
      repeat (n) begin
        if ($urandom_range(0, 99) < 10) send_noise();
        if ($urandom_range(0, 99) < 5)
          send_op(MODE_CANCEL, pg, STACK_IN_W'($urandom_range(0, 3)), pick_count());
        else
          send_op(MODE_FREE, pg, STACK_IN_W'($urandom_range(0, 3)),
                  COUNT_IN_W'($urandom_range(0, 65535)));
      end
      if ($urandom_range(0, 99) < 60)
        send_op(MODE_POP, PAGE_IN_W'($urandom_range(0, 255)), stk, pick_count());
    end else begin
      send_noise();
    end
  endtask

  task automatic send_directed();
    send_op(MODE_MARK,   8'd0,   2'd0, 16'd1);
    send_op(MODE_FREE,   8'd0,   2'd0, 16'd0);
    send_op(MODE_POP,    8'd0,   2'd0, 16'd0);
    send_op(MODE_POP,    8'd0,   2'd0, 16'd0);     // empty stack
    send_op(MODE_FREE,   8'd5,   2'd1, 16'd1);     // page never armed
    send_op(MODE_MARK,   8'd255, 2'd3, 16'd0);     // armed with zero count
    send_op(MODE_FREE,   8'd255, 2'd3, 16'd0);     // wraps to all ones, no push
    send_op(MODE_CANCEL, 8'd255, 2'd0, 16'd0);
    send_op(MODE_CANCEL, 8'd255, 2'd0, 16'd0);     // already disarmed
    send_op(MODE_MARK,   8'd170, 2'd2, 16'hFFFF);
    send_op(MODE_MARK,   8'd85,  2'd1, 16'd2);
    send_op(MODE_FREE,   8'd85,  2'd2, 16'h5555);
    send_op(MODE_FREE,   8'd85,  2'd3, 16'hAAAA);
    send_op(MODE_MARK,   8'd85,  2'd2, 16'd1);     // page still on stack 1
    send_op(MODE_FREE,   8'd85,  2'd0, 16'd0);
    send_op(MODE_POP,    8'd0,   2'd1, 16'd0);
    send_op(MODE_POP,    8'd0,   2'd2, 16'd0);
    send_op(MODE_POP,    8'd0,   2'd2, 16'd0);
    send_op(MODE_MARK,   8'd170, 2'd1, 16'hAAAA);
    send_op(MODE_CANCEL, 8'd170, 2'd2, 16'h5555);
    send_op(MODE_MARK,   8'd3,   2'd3, 16'd1);
    send_op(MODE_FREE,   8'd3,   2'd3, 16'd0);
    send_op(MODE_MARK,   8'd3,   2'd3, 16'd1);
    send_op(MODE_FREE,   8'd3,   2'd3, 16'd0);     // page links to itself
    send_op(MODE_POP,    8'd255, 2'd3, 16'hFFFF);
  endtask

  initial begin
    sent = 0;
    idle_pct = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= MODE_MARK;
    in_page_index <= '0;
    in_stack_index <= '0;
    in_outstanding_count <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < 3; p++) begin
      idle_pct = idle_by_phase[p];
      if (p == 0) send_directed();
      while (sent < (p + 1) * 340) send_round();
      // hold off until every result of this phase is back
      wait_drained();
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/rprs_pkg.sv
sv/rprs_page_mem.sv
sv/rprs_stack_file.sv
sv/retired_page_ready_stack_top.sv
sv/rprs_checker.sv
tb/sv/page_stack_checker.sv
tb/sv/tb_top.sv
